/* src/kmpt_pkg.sv */
// Package for the keyboard/mouse packet tracker: types, codes, constants, helpers.
package kmpt_pkg;

    // Register reset values and fixed constants
    localparam int QUEUE_DEPTH_DEFAULT = 256;
    localparam logic [9:0] MAX_X_RESET = 10'd628;
    localparam logic [8:0] MAX_Y_RESET = 9'd378;
    localparam logic [6:0] FPS_RESET = 7'd70;
    localparam logic [9:0] POS_X_RESET = 10'd320;
    localparam logic [8:0] POS_Y_RESET = 9'd200;
    localparam logic [7:0] HDR_MIN = 8'hF8;
    localparam logic [7:0] HDR_MAX_KNOWN = 8'hFB;

    // Request codes
    typedef enum logic [1:0] {
        REQ_RX_BYTE = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_READ    = 2'd2,
        REQ_FLUSH   = 2'd3
    } req_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MAX_X = 2'd0,
        CFG_MAX_Y = 2'd1,
        CFG_FPS   = 2'd2
    } cfg_idx_t;

    // Mouse packet parse phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DX   = 2'd1,
        PH_DY   = 2'd2
    } phase_t;

    // One result item
    typedef struct packed {
        logic [9:0]  cursor_x;
        logic [8:0]  cursor_y;
        logic [1:0]  buttons;
        logic [6:0]  key_code;
        logic        key_waiting;
        logic        key_held;
        logic [15:0] seconds_count;
    } result_t;

    // Add a signed byte delta to a position and clamp to [0, limit]
    function automatic logic [9:0] clamp_pos(input logic [9:0] pos,
                                             input logic [7:0] delta,
                                             input logic [9:0] limit);
        logic signed [11:0] sum;
        begin
            sum = $signed({2'b00, pos}) + $signed({{4{delta[7]}}, delta});
            if (sum < 12'sd0)
                clamp_pos = '0;
            else if (sum > $signed({2'b00, limit}))
                clamp_pos = limit;
            else
                clamp_pos = sum[9:0];
        end
    endfunction

endpackage

/* src/kmpt_if.sv */
// Valid/ready channel interfaces for requests and results.
interface kmpt_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic       advance_head;

    modport source (output valid, output req_type, output rx_byte, output advance_head,
                     input ready);
    modport sink (input valid, input req_type, input rx_byte, input advance_head,
                   output ready);
endinterface

interface kmpt_rsp_if;
    logic        valid;
    logic        ready;
    logic [9:0]  cursor_x;
    logic [8:0]  cursor_y;
    logic [1:0]  buttons;
    logic [6:0]  key_code;
    logic        key_waiting;
    logic        key_held;
    logic [15:0] seconds_count;

    modport source (output valid, output cursor_x, output cursor_y, output buttons,
                     output key_code, output key_waiting, output key_held,
                     output seconds_count, input ready);
    modport sink (input valid, input cursor_x, input cursor_y, input buttons,
                   input key_code, input key_waiting, input key_held,
                   input seconds_count, output ready);
endinterface

/* src/kbd_mouse_packet_tracker.sv */
// Top level: keyboard-controller byte decoder with mouse cursor and key code queue.
//
// Takes one request item per cycle (received byte, frame tick, key read, queue flush) and
// returns one result item for each, in order. All cursor, button, parse and frame state
// updates in the cycle an item is accepted; the key code queue sits in a synchronous
// memory of QUEUE_DEPTH entries with a registered read: each accepted item passes through
// the read stage register into the output buffer and is offered on rsp from there.
// Results wait in a three-entry buffer, and req.ready drops once the read stage and
// that buffer together hold three items; with rsp always ready the block sustains
// one item per cycle. Queue contents are not cleared at reset (no clearing pass); a
// code pushed to a full queue is dropped. Configuration writes take effect on the
// next item.
module kbd_mouse_packet_tracker #(
    parameter int QUEUE_DEPTH = kmpt_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    kmpt_req_if.sink   req,
    kmpt_rsp_if.source rsp,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [9:0] cfg_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(QUEUE_DEPTH);
    localparam int OB_DEPTH = 3;
    localparam logic [1:0] OB_LAST = 2'(OB_DEPTH - 1);

    // Configuration registers
    logic [9:0] max_x_reg;
    logic [8:0] max_y_reg;
    logic [6:0] fps_reg;

    // Decoder state
    kmpt_pkg::phase_t phase_reg, phase_next;
    logic [1:0]    hdr_btn_reg, hdr_btn_next;
    logic          hdr_known_reg, hdr_known_next;
    logic [7:0]    dx_reg, dx_next;
    logic [7:0]    dy_reg, dy_next;
    logic [9:0]    pos_x_reg, pos_x_next;
    logic [8:0]    pos_y_reg, pos_y_next;
    logic [1:0]    btn_reg, btn_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          rpt_reg, rpt_next;
    logic [6:0]    frame_reg, frame_next;
    logic [15:0]   sec_reg, sec_next;

    // Queue memory
    logic [6:0]    key_mem [QUEUE_DEPTH];
    logic [6:0]    mem_rdata_reg;
    logic          mem_we;

    // Read stage and output buffer
    logic                s1_valid_reg;
    logic                s1_code_en_reg;
    kmpt_pkg::result_t   s1_res_reg;
    kmpt_pkg::result_t   res_next;
    logic                code_en_next;
    kmpt_pkg::result_t   s1_res_full;
    kmpt_pkg::result_t   ob_mem [OB_DEPTH];
    logic [1:0]          ob_head_reg, ob_tail_reg, ob_cnt_reg;
    logic [2:0]          occ;
    logic                acc, pop;

    logic [6:0] frame_inc;

    assign occ       = {2'b00, s1_valid_reg} + {1'b0, ob_cnt_reg};
    assign req.ready = (occ < 3'(OB_DEPTH));
    assign acc       = req.valid && req.ready;
    assign pop       = rsp.valid && rsp.ready;
    assign frame_inc = frame_reg + 7'd1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= kmpt_pkg::MAX_X_RESET;
            max_y_reg <= kmpt_pkg::MAX_Y_RESET;
            fps_reg   <= kmpt_pkg::FPS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kmpt_pkg::CFG_MAX_X: max_x_reg <= cfg_data;
                kmpt_pkg::CFG_MAX_Y: max_y_reg <= cfg_data[8:0];
                kmpt_pkg::CFG_FPS:   fps_reg   <= cfg_data[6:0];
                default:             ;
            endcase
        end
    end

    // Next state and result of an accepted item
    always_comb
    begin
        phase_next     = phase_reg;
        hdr_btn_next   = hdr_btn_reg;
        hdr_known_next = hdr_known_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        btn_next       = btn_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        fill_next      = fill_reg;
        rpt_next       = rpt_reg;
        frame_next     = frame_reg;
        sec_next       = sec_reg;
        mem_we         = 1'b0;
        code_en_next   = 1'b0;

        if (acc)
        begin
            unique case (kmpt_pkg::req_t'(req.req_type))
                kmpt_pkg::REQ_RX_BYTE:
                begin
                    priority if (phase_reg == kmpt_pkg::PH_DX)
                    begin
                        dx_next    = req.rx_byte;
                        phase_next = kmpt_pkg::PH_DY;
                    end
                    else if (phase_reg == kmpt_pkg::PH_DY)
                    begin
                        dy_next    = req.rx_byte;
                        phase_next = kmpt_pkg::PH_IDLE;
                    end
                    else if (req.rx_byte >= kmpt_pkg::HDR_MIN)
                    begin
                        hdr_btn_next   = req.rx_byte[1:0];
                        hdr_known_next = (req.rx_byte <= kmpt_pkg::HDR_MAX_KNOWN);
                        phase_next     = kmpt_pkg::PH_DX;
                    end
                    else if (!req.rx_byte[7])
                    begin
                        // make code: queue unless full
                        if (fill_reg != FILL_FULL)
                        begin
                            mem_we      = 1'b1;
                            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                            fill_next   = fill_reg + 1'b1;
                        end
                        rpt_next = 1'b1;
                    end
                    else
                    begin
                        rpt_next = 1'b0;
                    end
                end
                kmpt_pkg::REQ_TICK:
                begin
                    pos_x_next = kmpt_pkg::clamp_pos(pos_x_reg, dx_reg, max_x_reg);
                    pos_y_next = 9'(kmpt_pkg::clamp_pos({1'b0, pos_y_reg}, dy_reg,
                                                        {1'b0, max_y_reg}));
                    dx_next = '0;
                    dy_next = '0;
                    if (hdr_known_reg)
                        btn_next = hdr_btn_reg;
                    if (frame_inc == fps_reg)
                    begin
                        frame_next = '0;
                        sec_next   = sec_reg + 16'd1;
                    end
                    else
                    begin
                        frame_next = frame_inc;
                    end
                end
                kmpt_pkg::REQ_READ:
                begin
                    if (fill_reg != '0)
                    begin
                        code_en_next = 1'b1;
                        if (req.advance_head)
                        begin
                            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
                            fill_next   = fill_reg - 1'b1;
                        end
                    end
                end
                kmpt_pkg::REQ_FLUSH:
                begin
                    rd_ptr_next = wr_ptr_reg;
                    fill_next   = '0;
                end
                default: ;
            endcase
        end

        res_next.cursor_x      = pos_x_next;
        res_next.cursor_y      = pos_y_next;
        res_next.buttons       = btn_next;
        res_next.key_code      = '0;
        res_next.key_waiting   = (fill_next != '0);
        res_next.key_held      = rpt_next;
        res_next.seconds_count = sec_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= kmpt_pkg::PH_IDLE;
            hdr_btn_reg   <= '0;
            hdr_known_reg <= 1'b0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            pos_x_reg     <= kmpt_pkg::POS_X_RESET;
            pos_y_reg     <= kmpt_pkg::POS_Y_RESET;
            btn_reg       <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            rpt_reg       <= 1'b0;
            frame_reg     <= '0;
            sec_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_btn_reg   <= hdr_btn_next;
            hdr_known_reg <= hdr_known_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            btn_reg       <= btn_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            fill_reg      <= fill_next;
            rpt_reg       <= rpt_next;
            frame_reg     <= frame_next;
            sec_reg       <= sec_next;
        end
    end

    // Queue memory: write at tail, registered read at head
    always_ff @(posedge clk)
    begin
        if (mem_we)
            key_mem[wr_ptr_reg] <= req.rx_byte[6:0];
        if (acc)
            mem_rdata_reg <= key_mem[rd_ptr_reg];
    end

    // Read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= acc;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_res_reg     <= res_next;
            s1_code_en_reg <= code_en_next;
        end
    end

    always_comb
    begin
        s1_res_full          = s1_res_reg;
        s1_res_full.key_code = s1_code_en_reg ? mem_rdata_reg : '0;
    end

    // Output buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_head_reg <= '0;
            ob_tail_reg <= '0;
            ob_cnt_reg  <= '0;
        end
        else
        begin
            if (s1_valid_reg)
                ob_tail_reg <= (ob_tail_reg == OB_LAST) ? '0 : ob_tail_reg + 2'd1;
            if (pop)
                ob_head_reg <= (ob_head_reg == OB_LAST) ? '0 : ob_head_reg + 2'd1;
            ob_cnt_reg <= ob_cnt_reg + {1'b0, s1_valid_reg} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            ob_mem[ob_tail_reg] <= s1_res_full;
    end

    assign rsp.valid         = (ob_cnt_reg != '0);
    assign rsp.cursor_x      = ob_mem[ob_head_reg].cursor_x;
    assign rsp.cursor_y      = ob_mem[ob_head_reg].cursor_y;
    assign rsp.buttons       = ob_mem[ob_head_reg].buttons;
    assign rsp.key_code      = ob_mem[ob_head_reg].key_code;
    assign rsp.key_waiting   = ob_mem[ob_head_reg].key_waiting;
    assign rsp.key_held      = ob_mem[ob_head_reg].key_held;
    assign rsp.seconds_count = ob_mem[ob_head_reg].seconds_count;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("queue fill beyond depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("empty queue with unequal pointers");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ <= 3'(OB_DEPTH))
        else $error("result buffer overflow");

    a_read_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> s1_valid_reg)
        else $error("accepted item lost before read stage");

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the keyboard/mouse packet tracker: cursor, buttons, key queue, seconds.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kmpt_pkg::*;

    localparam int KEY_SLOTS = QUEUE_DEPTH_DEFAULT;

    // Tracks cursor, button and key queue state; holds the results still owed by the block
    class cursor_key_scoreboard;
        logic [9:0]  lim_x;
        logic [8:0]  lim_y;
        logic [6:0]  fps;
        phase_t      phase;
        logic [1:0]  hdr_buttons;
        bit          hdr_known;
        logic [7:0]  dx;
        logic [7:0]  dy;
        logic [9:0]  pos_x;
        logic [8:0]  pos_y;
        logic [1:0]  btn;
        logic [6:0]  codes[KEY_SLOTS];
        int          rd_ptr;
        int          wr_ptr;
        int          fill;
        bit          held;
        logic [6:0]  frames;
        logic [15:0] secs;
        result_t     due[$];
        int          errors;

        function new();
            lim_x = MAX_X_RESET;
            lim_y = MAX_Y_RESET;
            fps = FPS_RESET;
            phase = PH_IDLE;
            hdr_buttons = '0;
            hdr_known = 1'b0;
            dx = '0;
            dy = '0;
            pos_x = POS_X_RESET;
            pos_y = POS_Y_RESET;
            btn = '0;
            rd_ptr = 0;
            wr_ptr = 0;
            fill = 0;
            held = 1'b0;
            frames = '0;
            secs = '0;
            errors = 0;
        endfunction

        function void set_register(cfg_idx_t idx, logic [9:0] val);
            case (idx)
                CFG_MAX_X: lim_x = val;
                CFG_MAX_Y: lim_y = val[8:0];
                CFG_FPS:   fps = val[6:0];
                default:   ;
            endcase
        endfunction

        // Signed byte step on one axis, clamped to [0, limit]
        function int move_axis(int pos, logic [7:0] d, int limit);
            int s;
            s = pos + int'($signed(d));
            if (s < 0)
                s = 0;
            if (s > limit)
                s = limit;
            return s;
        endfunction

        // Apply one accepted request item and queue the result it should produce
        function void note_request(req_t kind, logic [7:0] b, bit adv);
            result_t r;
            logic [6:0] code;
            code = '0;
            case (kind)
                REQ_RX_BYTE:
                begin
                    if (phase == PH_DX)
                    begin
                        dx = b;
                        phase = PH_DY;
                    end
                    else if (phase == PH_DY)
                    begin
                        dy = b;
                        phase = PH_IDLE;
                    end
                    else if (b >= HDR_MIN)
                    begin
                        hdr_buttons = b[1:0];
                        hdr_known = (b <= HDR_MAX_KNOWN);
                        phase = PH_DX;
                    end
                    else if (!b[7])
                    begin
                        // make code: dropped when the queue is full, flag set regardless
                        if (fill < KEY_SLOTS)
                        begin
                            codes[wr_ptr] = b[6:0];
                            wr_ptr = (wr_ptr + 1) % KEY_SLOTS;
                            fill++;
                        end
                        held = 1'b1;
                    end
                    else
                        held = 1'b0;
                end
                REQ_TICK:
                begin
                    pos_x = 10'(move_axis(int'(pos_x), dx, int'(lim_x)));
                    pos_y = 9'(move_axis(int'(pos_y), dy, int'(lim_y)));
                    dx = '0;
                    dy = '0;
                    if (hdr_known)
                        btn = hdr_buttons;
                    frames = frames + 7'd1;
                    if (frames == fps)
                    begin
                        frames = '0;
                        secs = secs + 16'd1;
                    end
                end
                REQ_READ:
                begin
                    if (fill != 0)
                    begin
                        code = codes[rd_ptr];
                        if (adv)
                        begin
                            rd_ptr = (rd_ptr + 1) % KEY_SLOTS;
                            fill--;
                        end
                    end
                end
                default:
                begin
                    rd_ptr = wr_ptr;
                    fill = 0;
                end
            endcase
            r.cursor_x = pos_x;
            r.cursor_y = pos_y;
            r.buttons = btn;
            r.key_code = code;
            r.key_waiting = (fill != 0);
            r.key_held = held;
            r.seconds_count = secs;
            due.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            end
        endfunction

        // Compare one accepted result item with the oldest one owed
        function void check_result(result_t got);
            result_t want;
            if (due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result item %p", $time, got);
                return;
            end
            want = due.pop_front();
            compare_field("cursor_x", 16'(want.cursor_x), 16'(got.cursor_x));
            compare_field("cursor_y", 16'(want.cursor_y), 16'(got.cursor_y));
            compare_field("buttons", 16'(want.buttons), 16'(got.buttons));
            compare_field("key_code", 16'(want.key_code), 16'(got.key_code));
            compare_field("key_waiting", 16'(want.key_waiting), 16'(got.key_waiting));
            compare_field("key_held", 16'(want.key_held), 16'(got.key_held));
            compare_field("seconds_count", want.seconds_count, got.seconds_count);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [9:0] cfg_data;
    int         tx_idle_pct;
    int         rx_idle_pct;
    int         items_sent;

    kmpt_req_if req_ch();
    kmpt_rsp_if rsp_ch();

    cursor_key_scoreboard sb = new();

    kbd_mouse_packet_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver stalls
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result('{cursor_x: rsp_ch.cursor_x, cursor_y: rsp_ch.cursor_y,
                              buttons: rsp_ch.buttons, key_code: rsp_ch.key_code,
                              key_waiting: rsp_ch.key_waiting, key_held: rsp_ch.key_held,
                              seconds_count: rsp_ch.seconds_count});
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Drive one request item; called and returns at a falling edge
    task automatic send_item(req_t kind, logic [7:0] b, bit adv);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.rx_byte <= b;
        req_ch.advance_head <= adv;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(kind, b, adv);
        items_sent++;
        @(negedge clk);
    endtask

    // Stop sending and wait until every owed result has come back
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [9:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        sb.set_register(idx, val);
    endtask

    task automatic configure(logic [9:0] x, logic [8:0] y, logic [6:0] f);
        write_reg(CFG_MAX_X, x);
        write_reg(CFG_MAX_Y, {1'b0, y});
        write_reg(CFG_FPS, {3'b000, f});
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Occasional tick or read wedged inside a mouse packet
    task automatic maybe_interject();
        if ($urandom_range(9) == 0)
            send_item($urandom_range(1) ? REQ_TICK : REQ_READ, 8'($urandom), 1'($urandom));
    endtask

    // Push past the queue capacity, then pop a few
    task automatic fill_queue();
        repeat (KEY_SLOTS + 6)
            send_item(REQ_RX_BYTE, 8'($urandom_range(127)), 1'($urandom));
        repeat (3)
            send_item(REQ_READ, 8'($urandom), 1'b1);
    endtask

    // One random sequence: mostly well-formed packets and key events, some noise
    task automatic random_sequence();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            send_item(REQ_RX_BYTE, 8'($urandom_range(8'hFF, 8'hF8)), 1'($urandom));
            maybe_interject();
            send_item(REQ_RX_BYTE, 8'($urandom), 1'($urandom));
            maybe_interject();
            send_item(REQ_RX_BYTE, 8'($urandom), 1'($urandom));
        end
        else if (pick < 60)
        begin
            if ($urandom_range(2) != 0)
                send_item(REQ_RX_BYTE, 8'($urandom_range(127)), 1'($urandom));
            else
                send_item(REQ_RX_BYTE, 8'($urandom_range(8'hF7, 8'h80)), 1'($urandom));
        end
        else if (pick < 75)
            send_item(REQ_TICK, 8'($urandom), 1'($urandom));
        else if (pick < 90)
            send_item(REQ_READ, 8'($urandom), 1'($urandom));
        else if (pick < 95)
            send_item(REQ_FLUSH, 8'($urandom), 1'($urandom));
        else
            send_item(req_t'($urandom_range(3)), 8'($urandom), 1'($urandom));
    endtask

    // Main sequence
    initial
    begin
        int target;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_RX_BYTE;
        req_ch.rx_byte <= '0;
        req_ch.advance_head <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_MAX_X;
        cfg_data <= '0;
        rst_n <= 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        items_sent = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty read, tick before any header
        send_item(REQ_READ, 8'h00, 1'b1);
        send_item(REQ_TICK, 8'h00, 1'b0);
        // known header with extreme deltas
        send_item(REQ_RX_BYTE, 8'hF9, 1'b0);
        send_item(REQ_RX_BYTE, 8'h7F, 1'b0);
        send_item(REQ_RX_BYTE, 8'h80, 1'b0);
        send_item(REQ_TICK, 8'hFF, 1'b1);
        // unknown header: buttons must not change
        send_item(REQ_RX_BYTE, 8'hFF, 1'b0);
        send_item(REQ_RX_BYTE, 8'h80, 1'b0);
        send_item(REQ_RX_BYTE, 8'h7F, 1'b0);
        send_item(REQ_TICK, 8'h00, 1'b0);
        // make and break code extremes, reads with and without pop
        send_item(REQ_RX_BYTE, 8'h00, 1'b0);
        send_item(REQ_RX_BYTE, 8'h7F, 1'b0);
        send_item(REQ_RX_BYTE, 8'h80, 1'b0);
        send_item(REQ_RX_BYTE, 8'hF7, 1'b0);
        send_item(REQ_READ, 8'h00, 1'b0);
        send_item(REQ_READ, 8'h00, 1'b1);
        send_item(REQ_READ, 8'h00, 1'b1);
        send_item(REQ_READ, 8'h00, 1'b1);
        // flush a pending code
        send_item(REQ_RX_BYTE, 8'h55, 1'b1);
        send_item(REQ_FLUSH, 8'hAA, 1'b1);
        send_item(REQ_READ, 8'h00, 1'b1);
        // tick in the middle of a packet, header byte value as a delta
        send_item(REQ_RX_BYTE, 8'hF8, 1'b0);
        send_item(REQ_RX_BYTE, 8'hFF, 1'b0);
        send_item(REQ_TICK, 8'h00, 1'b0);
        send_item(REQ_RX_BYTE, 8'h01, 1'b0);
        send_item(REQ_TICK, 8'h00, 1'b0);
        settle();

        // Random phases, each with its own register setting and one of three idling mixes
        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg)
                0:       configure(10'd1023, 9'd511, 7'd1);
                1:       configure(10'd0, 9'd0, 7'd127);
                2:       configure(10'd700, 9'd300, 7'd0);
                3:       configure(10'($urandom), 9'($urandom), 7'($urandom_range(127, 1)));
                4:       configure(MAX_X_RESET, MAX_Y_RESET, FPS_RESET);
                default: configure(10'($urandom), 9'($urandom), 7'd2);
            endcase
            tx_idle_pct = (seg < 2) ? 31 : (seg < 4) ? 75 : 0;
            rx_idle_pct = (seg < 2) ? 75 : (seg < 4) ? 31 : 0;
            if (seg == 1 || seg == 4)
                fill_queue();
            target = items_sent + 105;
            while (items_sent < target)
                random_sequence();
            settle();
        end

        if (sb.due.size() != 0)
            $display("%0t: %0d result items never arrived", $time, sb.due.size());
        if (sb.errors == 0 && sb.due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
